/* rtl/page_frame_bitmap_allocator_macros.svh */
// Assertion macros for the checker file of the page frame allocator.
// No dependencies; include by bare file name where assertions are written.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PFBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfba assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfba assertion failed");

`endif

/* rtl/pfba_pkg.sv */
// Package for the page frame bitmap allocator: sizes, codes and the set-bit finder.
// No dependencies; used by the top level, the checker and the bench.
package pfba_pkg;

    // Page index width; leaf words hold 64 pages each (valid range 6..12)
    localparam int PAGE_INDEX_BITS = 12;
    localparam int PAGE_W          = 12;
    localparam int LIMIT_W         = 13;
    localparam int WORD_W          = 64;
    localparam int BIT_W           = 6;
    localparam int LEAF_COUNT      = 1 << (PAGE_INDEX_BITS - BIT_W);
    localparam int LEAF_W          = (PAGE_INDEX_BITS > BIT_W) ? PAGE_INDEX_BITS - BIT_W : 1;
    localparam int PAGE_SPACE      = 1 << PAGE_INDEX_BITS;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 16;
    localparam int STAT_W          = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // Item kinds carried on s_tuser
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status carried on m_tuser
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Lowest (low=1) or highest (low=0) set bit of a word.
    // Zero word: 63 for lowest, 0 for highest. Six halving steps.
    function automatic logic [BIT_W-1:0] find_set(input logic [WORD_W-1:0] v,
                                                   input logic low);
        logic [WORD_W-1:0] w;
        logic [BIT_W-1:0]  pos;
        for (int i = 0; i < WORD_W; i++)
        begin
            w[i] = low ? v[i] : v[WORD_W-1-i];
        end
        pos = '0;
        for (int lvl = BIT_W - 1; lvl >= 0; lvl--)
        begin
            if ((w & ((WORD_W'(1) << (1 << lvl)) - WORD_W'(1))) == '0)
            begin
                pos[lvl] = 1'b1;
                w = w >> (1 << lvl);
            end
        end
        return low ? pos : (BIT_W'(WORD_W - 1) - pos);
    endfunction

endpackage

/* rtl/page_frame_bitmap_allocator.sv */
// Top level of the page frame bitmap allocator: summary register, leaf memory, sequencer.
// Depends on pfba_pkg.
//
// Usage:
//   Input stream: s_tuser[0] is the kind (0 allocate, 1 free); s_tdata holds
//   search_low in bit 0 and the page index in bits 12:1.
//   Output stream: m_tdata[11:0] is the page (allocated or echoed, 0 on error),
//   m_tuser[1:0] the status (0 ok, 1 no free page, 2 page out of range).
//   page_limit is written through cfg_we/cfg_wdata while the block is idle.
//   One item is worked at a time. For an allocate, a shared set-bit finder is used
//   first on the summary word, then on the leaf word read from the single-port
//   leaf memory; the leaf is written back in the cycle after the read. Empty-map
//   and out-of-range items give their result from LOOK and skip UPDATE.
//   Results sit in an output register; while the receiver stalls the next item
//   is still accepted and worked, and waits in a holding register if the
//   output is still full, with s_tready low until it moves on.
//   Reset clears the summary word and sets page_limit to 4096. The summary bit
//   of a leaf marks its memory word valid, so no clearing pass is needed and
//   the block is ready straight out of reset.
module page_frame_bitmap_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pfba_pkg::IN_TDATA_W-1:0]    s_tdata,    // [0] search_low, [12:1] page
    input  logic [0:0]                         s_tuser,    // [0] mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pfba_pkg::OUT_TDATA_W-1:0]   m_tdata,    // [11:0] page_out
    output logic [pfba_pkg::STAT_W-1:0]        m_tuser,    // [1:0] status
    input  logic                               cfg_we,
    input  logic [pfba_pkg::LIMIT_W-1:0]       cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    localparam logic [pfba_pkg::LEAF_W-1:0] LEAF_MASK =
        pfba_pkg::LEAF_W'(pfba_pkg::LEAF_COUNT - 1);
    localparam logic [pfba_pkg::LIMIT_W-1:0] SPACE_LIMIT =
        pfba_pkg::LIMIT_W'(pfba_pkg::PAGE_SPACE);

    state_t                              state_reg, state_next;
    logic                                mode_reg;
    logic                                low_reg;
    logic [pfba_pkg::PAGE_W-1:0]         page_reg;
    logic [pfba_pkg::LIMIT_W-1:0]        limit_reg;
    logic [pfba_pkg::LEAF_COUNT-1:0]     summary_reg, summary_next;
    logic [pfba_pkg::LEAF_W-1:0]         idx_reg, idx_next;
    logic [pfba_pkg::PAGE_W-1:0]         res_page_reg, res_page_next;
    logic [pfba_pkg::STAT_W-1:0]         res_status_reg, res_status_next;
    logic                                out_valid_reg, out_valid_next;
    logic [pfba_pkg::PAGE_W-1:0]         out_page_reg, out_page_next;
    logic [pfba_pkg::STAT_W-1:0]         out_status_reg, out_status_next;
    logic [pfba_pkg::WORD_W-1:0]         rd_data_reg;

    // Leaf memory, one 64-bit word per summary bit
    logic [pfba_pkg::WORD_W-1:0]         leaf_mem [pfba_pkg::LEAF_COUNT];

    logic                                mem_re;
    logic                                mem_we;
    logic [pfba_pkg::WORD_W-1:0]         mem_wdata;

    logic [pfba_pkg::WORD_W-1:0]         find_in;
    logic [pfba_pkg::BIT_W-1:0]          find_pos;
    logic [pfba_pkg::LIMIT_W-1:0]        lim_eff;
    logic                                out_of_range;
    logic [pfba_pkg::WORD_W-1:0]         leaf_cur;
    logic [pfba_pkg::WORD_W-1:0]         bit_mask;
    logic [pfba_pkg::LEAF_W-1:0]         free_idx;
    logic                                finish;
    logic                                out_free;

    // Shared set-bit finder: summary word in LOOK, leaf word in UPDATE
    assign leaf_cur = summary_reg[idx_reg] ? rd_data_reg : '0;
    assign find_in  = (state_reg == S_LOOK) ? pfba_pkg::WORD_W'(summary_reg) : leaf_cur;
    assign find_pos = pfba_pkg::find_set(find_in, low_reg);

    // Range check against the smaller of page_limit and the page space
    assign lim_eff      = (limit_reg > SPACE_LIMIT) ? SPACE_LIMIT : limit_reg;
    assign out_of_range = {1'b0, page_reg} >= lim_eff;
    assign free_idx     = pfba_pkg::LEAF_W'(page_reg >> pfba_pkg::BIT_W) & LEAF_MASK;

    assign out_free = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        summary_next    = summary_reg;
        idx_next        = idx_reg;
        res_page_next   = '0;
        res_status_next = pfba_pkg::STAT_OK;
        finish          = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        bit_mask        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (mode_reg == pfba_pkg::MODE_ALLOC)
                begin
                    if (summary_reg == '0)
                    begin
                        res_status_next = pfba_pkg::STAT_EMPTY;
                        finish          = 1'b1;
                    end
                    else
                    begin
                        idx_next   = pfba_pkg::LEAF_W'(find_pos) & LEAF_MASK;
                        mem_re     = 1'b1;
                        state_next = S_UPDATE;
                    end
                end
                else
                begin
                    if (out_of_range)
                    begin
                        res_status_next = pfba_pkg::STAT_RANGE;
                        finish          = 1'b1;
                    end
                    else
                    begin
                        idx_next   = free_idx;
                        mem_re     = 1'b1;
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                if (mode_reg == pfba_pkg::MODE_ALLOC)
                begin
                    if (leaf_cur == '0)
                    begin
                        res_status_next = pfba_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        bit_mask  = pfba_pkg::WORD_W'(1) << find_pos;
                        mem_wdata = leaf_cur & ~bit_mask;
                        mem_we    = 1'b1;
                        if (mem_wdata == '0)
                        begin
                            summary_next[idx_reg] = 1'b0;
                        end
                        res_page_next = (pfba_pkg::PAGE_W'(idx_reg) << pfba_pkg::BIT_W)
                                      | pfba_pkg::PAGE_W'(find_pos);
                    end
                end
                else
                begin
                    bit_mask  = pfba_pkg::WORD_W'(1) << page_reg[pfba_pkg::BIT_W-1:0];
                    mem_wdata = leaf_cur | bit_mask;
                    mem_we    = 1'b1;
                    summary_next[idx_reg] = 1'b1;
                    res_page_next = page_reg;
                end
                finish = 1'b1;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = out_free ? S_IDLE : S_RESP;
        end
    end

    // Output register loading
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish && out_free)
        begin
            out_valid_next  = 1'b1;
            out_page_next   = res_page_next;
            out_status_next = res_status_next;
        end
        else if (state_reg == S_RESP && out_free)
        begin
            out_valid_next  = 1'b1;
            out_page_next   = res_page_reg;
            out_status_next = res_status_reg;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            summary_reg   <= '0;
            limit_reg     <= pfba_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            summary_reg   <= summary_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg <= s_tuser[0];
            low_reg  <= s_tdata[0];
            page_reg <= s_tdata[pfba_pkg::PAGE_W:1];
        end
        idx_reg        <= idx_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
        if (finish)
        begin
            res_page_reg   <= res_page_next;
            res_status_reg <= res_status_next;
        end
    end

    // Leaf memory: one read or one write per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            leaf_mem[idx_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= leaf_mem[idx_next];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pfba_pkg::OUT_TDATA_W'(out_page_reg);
    assign m_tuser  = out_status_reg;

endmodule

/* rtl/pfba_checker.sv */
// Port-level checker for the page frame bitmap allocator, bound to the top level.
// Depends on pfba_pkg and page_frame_bitmap_allocator_macros.svh.
`include "page_frame_bitmap_allocator_macros.svh"

module pfba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [pfba_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic [0:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pfba_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [pfba_pkg::STAT_W-1:0]       m_tuser,
    input logic                              cfg_we
);

    // One item in flight: ready drops right after each input transaction
    `PFBA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // Error results always carry page zero
    `PFBA_ASSERT_IMPL(a_err_page_zero, m_tvalid && (m_tuser != pfba_pkg::STAT_OK), m_tdata == '0)

    // A stalled result holds
    `PFBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A waiting input transaction holds
    `PFBA_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable({s_tuser, s_tdata}))

    // Limit writes only land while the block is idle and the output is empty
    `PFBA_ASSERT_IMPL(a_cfg_idle, cfg_we, s_tready && !m_tvalid)

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (.*);

/* bench/pfba_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the page frame bitmap allocator bench: watches both streams and the
// limit register port, keeps its own free map, and compares every result in order.
// Depends on pfba_pkg.
module pfba_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [pfba_pkg::IN_TDATA_W-1:0]    s_tdata,    // [0] search_low, [12:1] page
    input  logic [0:0]                         s_tuser,    // [0] mode
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [pfba_pkg::OUT_TDATA_W-1:0]   m_tdata,    // [11:0] page_out
    input  logic [pfba_pkg::STAT_W-1:0]        m_tuser,    // [1:0] status
    input  logic                               cfg_we,
    input  logic [pfba_pkg::LIMIT_W-1:0]       cfg_wdata,
    output int                                 fail_count,
    output int                                 outstanding
);

    typedef struct packed {
        logic [pfba_pkg::PAGE_W-1:0] page;
        logic [pfba_pkg::STAT_W-1:0] status;
    } page_reply_t;

    // Shadow free map: one bit per page, set when free
    logic [pfba_pkg::WORD_W-1:0]  free_leaf [pfba_pkg::LEAF_COUNT];
    logic [pfba_pkg::WORD_W-1:0]  free_summary;
    logic [pfba_pkg::LIMIT_W-1:0] frame_limit;

    page_reply_t predicted_replies [$];
    page_reply_t want;

    // Lowest (low=1) or highest (low=0) set bit; callers never pass zero
    function automatic int pick_set_bit(input logic [pfba_pkg::WORD_W-1:0] v,
                                        input logic low);
        int pos;
        int k;
        pos = 0;
        for (int i = 0; i < pfba_pkg::WORD_W; i++)
        begin
            k = low ? pfba_pkg::WORD_W - 1 - i : i;
            if (v[k])
                pos = k;
        end
        return pos;
    endfunction

    // Apply one allocate/free to the shadow map and return the reply it gives
    function automatic page_reply_t apply_page_op(input logic mode, input logic low,
                                                  input logic [pfba_pkg::PAGE_W-1:0] pg);
        page_reply_t                 r;
        logic [pfba_pkg::WORD_W-1:0] live;
        int                          w;
        int                          b;
        int                          lim;
        r.page   = '0;
        r.status = pfba_pkg::STAT_OK;
        if (mode == pfba_pkg::MODE_ALLOC)
        begin
            // allocate ignores the limit; only leaves that exist are searched
            live = free_summary & ((pfba_pkg::WORD_W'(1) << pfba_pkg::LEAF_COUNT)
                                   - pfba_pkg::WORD_W'(1));
            if (live == '0)
            begin
                r.status = pfba_pkg::STAT_EMPTY;
            end
            else
            begin
                w = pick_set_bit(live, low);
                b = pick_set_bit(free_leaf[w], low);
                free_leaf[w][b] = 1'b0;
                if (free_leaf[w] == '0)
                    free_summary[w] = 1'b0;
                r.page = pfba_pkg::PAGE_W'(w * pfba_pkg::WORD_W + b);
            end
        end
        else
        begin
            lim = (frame_limit > pfba_pkg::PAGE_SPACE) ? pfba_pkg::PAGE_SPACE
                                                        : int'(frame_limit);
            if (int'(pg) >= lim)
            begin
                r.status = pfba_pkg::STAT_RANGE;
            end
            else
            begin
                w = int'(pg >> pfba_pkg::BIT_W) & (pfba_pkg::LEAF_COUNT - 1);
                b = int'(pg[pfba_pkg::BIT_W-1:0]);
                free_leaf[w][b] = 1'b1;
                free_summary[w] = 1'b1;
                r.page = pg;
            end
        end
        return r;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pfba_pkg::LEAF_COUNT; i++)
                free_leaf[i] = '0;
            free_summary = '0;
            frame_limit  = pfba_pkg::LIMIT_RESET;
            predicted_replies.delete();
            fail_count   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_replies.push_back(apply_page_op(s_tuser[0], s_tdata[0],
                                                          s_tdata[pfba_pkg::PAGE_W:1]));
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: result with nothing pending: page %0d status %0d",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_tdata != pfba_pkg::OUT_TDATA_W'(want.page))
                    begin
                        $display("%0t: page_out mismatch: expected %0d, got %0d",
                                 $time, want.page, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser != want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            // limit takes effect for transactions after the write edge
            if (cfg_we)
                frame_limit = cfg_wdata;
            outstanding <= predicted_replies.size();
        end
    end

endmodule

/* bench/tb_page_frame_bitmap_allocator.sv */
`timescale 1ns / 100ps
// Testbench top for the page frame bitmap allocator: clock, reset, stimulus and verdict.
// Depends on pfba_pkg, page_frame_bitmap_allocator and pfba_result_checker.
module tb_page_frame_bitmap_allocator;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 8;
    localparam int PHASE_COUNT      = 8;
    localparam int ITEMS_PER_PHASE  = 220;
    localparam int DRAIN_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT   = 1000;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [pfba_pkg::IN_TDATA_W-1:0]     s_tdata   = '0;   // [0] search_low, [12:1] page
    logic [0:0]                          s_tuser   = '0;   // [0] mode
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [pfba_pkg::OUT_TDATA_W-1:0]    m_tdata;          // [11:0] page_out
    logic [pfba_pkg::STAT_W-1:0]         m_tuser;          // [1:0] status
    logic                                cfg_we    = 1'b0;
    logic [pfba_pkg::LIMIT_W-1:0]        cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int burst_left   = 0;
    int ready_hold   = 0;
    int quiet_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    page_frame_bitmap_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    pfba_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver: free-flowing stretches, long stalls and short random toggling
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    m_tready  <= 1'b1;
                    ready_hold = $urandom_range(20, 120);
                end
                3:
                begin
                    m_tready  <= 1'b0;
                    ready_hold = $urandom_range(5, 30);
                end
                default:
                begin
                    m_tready  <= 1'($urandom_range(0, 1));
                    ready_hold = $urandom_range(1, 3);
                end
            endcase
        end
        else
        begin
            ready_hold--;
        end
    end

    // Watchdog: no transaction on any port for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One input transaction; called and returns at a falling edge.
    // Bursts of random length with random gaps in between.
    task automatic send_item(input logic mode, input logic low,
                             input logic [pfba_pkg::PAGE_W-1:0] pg);
        int gap;
        int r;
        if (burst_left == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(4, 30);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(pfba_pkg::IN_TDATA_W - pfba_pkg::PAGE_W - 1){1'b0}}, pg, low};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Limit write once every pending result has come back
    task automatic write_limit(input int value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pfba_pkg::LIMIT_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        burst_left = 0;
    endtask

    // Runs of frees (spread, clustered in one leaf, or at the corners),
    // runs of allocates, and some fully random noise
    task automatic run_random_phase(input int n_items, input int lim);
        int                          sent;
        int                          run_len;
        int                          kind;
        int                          top_page;
        int                          base_page;
        logic                        low;
        logic [pfba_pkg::PAGE_W-1:0] pg;
        sent     = 0;
        top_page = (lim > 0) ? lim - 1 : 0;
        while (sent < n_items)
        begin
            kind      = $urandom_range(0, 99);
            run_len   = $urandom_range(4, 30);
            low       = 1'($urandom_range(0, 1));
            base_page = ($urandom_range(0, top_page) >> pfba_pkg::BIT_W) << pfba_pkg::BIT_W;
            for (int i = 0; i < run_len && sent < n_items; i++)
            begin
                if (kind < 45)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4:
                            pg = pfba_pkg::PAGE_W'($urandom_range(0, top_page));
                        5, 6, 7:
                            pg = pfba_pkg::PAGE_W'(base_page
                                 + $urandom_range(0, pfba_pkg::WORD_W - 1));
                        8:
                            pg = pfba_pkg::PAGE_W'((lim < pfba_pkg::PAGE_SPACE) ? lim
                                                                                 : top_page);
                        default:
                            pg = ($urandom_range(0, 1) == 1) ? '0 : '1;
                    endcase
                    send_item(pfba_pkg::MODE_FREE, 1'($urandom_range(0, 1)), pg);
                end
                else if (kind < 80)
                begin
                    // runs with kind below 60 keep one search direction for the whole run
                    send_item(pfba_pkg::MODE_ALLOC,
                              (kind < 60) ? low : 1'($urandom_range(0, 1)),
                              pfba_pkg::PAGE_W'($urandom_range(0, pfba_pkg::PAGE_SPACE - 1)));
                end
                else
                begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              pfba_pkg::PAGE_W'($urandom_range(0, pfba_pkg::PAGE_SPACE - 1)));
                end
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int lim;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty map, first frees, double free, both search directions
        send_item(pfba_pkg::MODE_ALLOC, 1'b1, 12'd0);
        send_item(pfba_pkg::MODE_ALLOC, 1'b0, 12'd4095);
        send_item(pfba_pkg::MODE_FREE,  1'b0, 12'd0);
        send_item(pfba_pkg::MODE_FREE,  1'b1, 12'd4095);
        send_item(pfba_pkg::MODE_FREE,  1'b0, 12'd4095);
        send_item(pfba_pkg::MODE_ALLOC, 1'b0, 12'd0);
        send_item(pfba_pkg::MODE_ALLOC, 1'b1, 12'd4095);
        send_item(pfba_pkg::MODE_ALLOC, 1'b1, 12'd0);
        // leaf word edges
        send_item(pfba_pkg::MODE_FREE,  1'b0, 12'd63);
        send_item(pfba_pkg::MODE_FREE,  1'b1, 12'd64);
        send_item(pfba_pkg::MODE_FREE,  1'b0, 12'd2047);
        send_item(pfba_pkg::MODE_ALLOC, 1'b0, 12'd0);
        send_item(pfba_pkg::MODE_ALLOC, 1'b1, 12'd0);
        send_item(pfba_pkg::MODE_ALLOC, 1'b0, 12'd0);
        send_item(pfba_pkg::MODE_ALLOC, 1'b0, 12'd0);

        // zero limit rejects every free
        write_limit(0);
        send_item(pfba_pkg::MODE_FREE, 1'b0, 12'd0);
        send_item(pfba_pkg::MODE_FREE, 1'b1, 12'd4095);
        // single page
        write_limit(1);
        send_item(pfba_pkg::MODE_FREE, 1'b0, 12'd0);
        send_item(pfba_pkg::MODE_FREE, 1'b0, 12'd1);
        write_limit(pfba_pkg::PAGE_SPACE);
        send_item(pfba_pkg::MODE_FREE, 1'b1, 12'd4095);
        send_item(pfba_pkg::MODE_FREE, 1'b0, 12'd3000);
        // lowered limit: page freed above it can still be handed out
        write_limit(100);
        send_item(pfba_pkg::MODE_FREE,  1'b0, 12'd100);
        send_item(pfba_pkg::MODE_FREE,  1'b0, 12'd99);
        send_item(pfba_pkg::MODE_ALLOC, 1'b0, 12'd0);

        // random phases across a spread of limits
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                1:       lim = 0;
                2, 6:    lim = $urandom_range(0, pfba_pkg::PAGE_SPACE);
                3:       lim = pfba_pkg::PAGE_SPACE - 1;
                4:       lim = pfba_pkg::WORD_W;
                5:       lim = 1;
                default: lim = pfba_pkg::PAGE_SPACE;
            endcase
            write_limit(lim);
            run_random_phase(ITEMS_PER_PHASE, lim);
        end

        // drain and verdict
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
